/* sv/one_shot_timer_pool_core_assert.svh */
// ----------------------------------------------------------------------------
// One-shot timer pool assertion macros
// Immediate-style wrappers around concurrent properties on aclk / aresetn.
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_TIMER_POOL_CORE_ASSERT_SVH
`define ONE_SHOT_TIMER_POOL_CORE_ASSERT_SVH

// same-cycle implication
`define OTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/otp_pkg.sv */
// ----------------------------------------------------------------------------
// otp_pkg
// Types and constants shared by the one-shot timer pool.
// ----------------------------------------------------------------------------
package otp_pkg;

    localparam int TIMERS_DEFAULT = 16;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_CREATE  = 2'd1,
        CMD_STOP    = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_CREATED = 2'd0,
        KIND_FULL    = 2'd1,
        KIND_EXPIRED = 2'd2,
        KIND_DONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMD,
        ST_FIND,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [3:0]  slot;
        logic [31:0] arg;
        logic        last;
    } push_t;

endpackage

/* sv/one_shot_timer_pool_core.sv */
// ----------------------------------------------------------------------------
// one_shot_timer_pool_core
// Pool of one-shot timers with a wrapping millisecond counter.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes commands: tick, create, stop, restart. m_* channel
//   returns result items (kind, slot_out, arg_out, last); last marks the
//   final item caused by one command. A tick with no expiry returns nothing.
//   Timer start times and {delay, arg} sit in two synchronous memories with
//   registered reads; running bits are flip-flops.
//   One command is in work at a time; s_ready is high only while idle.
//   Stop and restart load their result from ST_CMD; create loads it from
//   ST_FIND once the free-slot search, which walks one running bit per
//   cycle, finds a free slot or reaches the last one; tick runs the memory
//   read pipeline, which checks one slot per cycle unless stalled. The next
//   command is taken the cycle after the last result is loaded into the output register.
//   An expiry is held in a register so last can be set on the highest expired slot; a
//   second expiry while the output register is full and m_ready low stalls
//   the scan until the transfer completes. Commands still enter while an
//   earlier result waits in the output register.
//   Reset (aresetn low, synchronous) clears the counter, stops all timers
//   and empties the output register; stores need no clearing.
// ----------------------------------------------------------------------------
module one_shot_timer_pool_core #(
    parameter int TIMERS = otp_pkg::TIMERS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_delay,
    input  logic [31:0] s_arg,
    input  logic [7:0]  s_slot,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [3:0]  m_slot_out,
    output logic [31:0] m_arg_out,
    output logic        m_last
);
    import otp_pkg::*;

    localparam int SLOT_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TIMERS - 1);

    // control state
    state_t             state_reg, state_next;
    logic [31:0]        now_ms_reg;
    logic [TIMERS-1:0]  running_reg;
    logic [SLOT_W-1:0]  scan_idx_reg;
    logic               iss_done_reg;
    logic               chk_valid_reg;
    logic [SLOT_W-1:0]  chk_idx_reg;
    logic               pend_valid_reg;
    logic [SLOT_W-1:0]  pend_slot_reg;
    logic [31:0]        pend_arg_reg;

    // latched command
    cmd_t               cmd_reg;
    logic [31:0]        dly_reg;
    logic [31:0]        arg_reg;
    logic [7:0]         slot_reg;

    // output register
    logic               m_valid_reg;
    kind_t              m_kind_reg;
    logic [3:0]         m_slot_out_reg;
    logic [31:0]        m_arg_out_reg;
    logic               m_last_reg;

    // memories
    logic [31:0]        start_mem [TIMERS];
    logic [63:0]        prm_mem   [TIMERS];
    logic [31:0]        start_rd_reg;
    logic [63:0]        prm_rd_reg;

    logic               s_xfer;
    logic               out_free;
    logic               slot_ok;
    logic [SLOT_W-1:0]  slot_idx;
    logic               find_free;
    logic               find_last;
    logic [31:0]        elapsed;
    logic               expired;
    logic               need_push;
    logic               advance;
    logic               drained;
    logic               rd_en;
    logic               create_we;
    logic               restart_we;
    logic               stop_clr;
    push_t              push;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign slot_ok   = (slot_reg < 8'(TIMERS));
    assign slot_idx  = slot_reg[SLOT_W-1:0];
    assign find_free = !running_reg[scan_idx_reg];
    assign find_last = (scan_idx_reg == LAST_IDX);
    assign elapsed   = now_ms_reg - start_rd_reg;
    assign expired   = chk_valid_reg && running_reg[chk_idx_reg]
                       && (elapsed >= prm_rd_reg[63:32]);
    // an expiry displaces the held one only if the output can take it
    assign need_push = expired && pend_valid_reg;
    assign advance   = !need_push || out_free;
    assign drained   = iss_done_reg && !chk_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    unique case (cmd_t'(s_command))
                        CMD_TICK:   state_next = ST_SCAN;
                        CMD_CREATE: state_next = ST_FIND;
                        default:    state_next = ST_CMD;
                    endcase
                end
            end
            ST_CMD: begin
                if (out_free) state_next = ST_IDLE;
            end
            ST_FIND: begin
                if ((find_free || find_last) && out_free) state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (drained && (!pend_valid_reg || out_free)) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        push       = '0;
        push.kind  = KIND_DONE;
        rd_en      = 1'b0;
        create_we  = 1'b0;
        restart_we = 1'b0;
        stop_clr   = 1'b0;
        unique case (state_reg)
            ST_IDLE: ;
            ST_CMD: begin
                push.valid = out_free;
                push.kind  = KIND_DONE;
                push.slot  = slot_reg[3:0];
                push.last  = 1'b1;
                restart_we = out_free && slot_ok && (cmd_reg == CMD_RESTART);
                stop_clr   = out_free && slot_ok && (cmd_reg == CMD_STOP);
            end
            ST_FIND: begin
                push.last = 1'b1;
                if (find_free) begin
                    push.valid = out_free;
                    push.kind  = KIND_CREATED;
                    push.slot  = 4'(scan_idx_reg);
                    create_we  = out_free;
                end else if (find_last) begin
                    push.valid = out_free;
                    push.kind  = KIND_FULL;
                end
            end
            ST_SCAN: begin
                push.kind = KIND_EXPIRED;
                push.slot = 4'(pend_slot_reg);
                push.arg  = pend_arg_reg;
                if (drained) begin
                    push.valid = pend_valid_reg && out_free;
                    push.last  = 1'b1;
                end else begin
                    push.valid = need_push && out_free;
                    rd_en      = advance && !iss_done_reg;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            now_ms_reg     <= '0;
            running_reg    <= '0;
            scan_idx_reg   <= '0;
            iss_done_reg   <= 1'b0;
            chk_valid_reg  <= 1'b0;
            chk_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (s_xfer) begin
                scan_idx_reg   <= '0;
                iss_done_reg   <= 1'b0;
                chk_valid_reg  <= 1'b0;
                pend_valid_reg <= 1'b0;
                if (cmd_t'(s_command) == CMD_TICK) now_ms_reg <= now_ms_reg + 32'd1;
            end

            if (stop_clr)  running_reg[slot_idx]     <= 1'b0;
            if (create_we) running_reg[scan_idx_reg] <= 1'b1;
            if (state_reg == ST_FIND && !find_free && !find_last)
                scan_idx_reg <= scan_idx_reg + 1'b1;

            if (state_reg == ST_SCAN && !drained && advance) begin
                if (expired) begin
                    running_reg[chk_idx_reg] <= 1'b0;
                    pend_valid_reg           <= 1'b1;
                end
                if (!iss_done_reg) begin
                    chk_valid_reg <= 1'b1;
                    chk_idx_reg   <= scan_idx_reg;
                    if (scan_idx_reg == LAST_IDX) iss_done_reg <= 1'b1;
                    else scan_idx_reg <= scan_idx_reg + 1'b1;
                end else begin
                    chk_valid_reg <= 1'b0;
                end
            end
            if (state_reg == ST_SCAN && drained && push.valid) pend_valid_reg <= 1'b0;

            if (push.valid)   m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            cmd_reg  <= cmd_t'(s_command);
            dly_reg  <= s_delay;
            arg_reg  <= s_arg;
            slot_reg <= s_slot;
        end
        if (state_reg == ST_SCAN && !drained && advance && expired) begin
            pend_slot_reg <= chk_idx_reg;
            pend_arg_reg  <= prm_rd_reg[31:0];
        end
        if (push.valid) begin
            m_kind_reg     <= push.kind;
            m_slot_out_reg <= push.slot;
            m_arg_out_reg  <= push.arg;
            m_last_reg     <= push.last;
        end
    end

    // start time store
    always_ff @(posedge aclk) begin
        if (create_we)  start_mem[scan_idx_reg] <= now_ms_reg;
        if (restart_we) start_mem[slot_idx]     <= now_ms_reg;
        if (rd_en)      start_rd_reg <= start_mem[scan_idx_reg];
    end

    // {delay, arg} store
    always_ff @(posedge aclk) begin
        if (create_we) prm_mem[scan_idx_reg] <= {dly_reg, arg_reg};
        if (rd_en)     prm_rd_reg <= prm_mem[scan_idx_reg];
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_slot_out = m_slot_out_reg;
    assign m_arg_out  = m_arg_out_reg;
    assign m_last     = m_last_reg;

    `include "one_shot_timer_pool_core_assert.svh"

    `OTP_ASSERT_NOW(a_push_room, push.valid, !m_valid_reg || m_ready,
                    "push into full output")
    `OTP_ASSERT_NOW(a_idle_empty, state_reg == ST_IDLE, !chk_valid_reg,
                    "check stage busy in idle")
    `OTP_ASSERT_NOW(a_stall_pend, state_reg == ST_SCAN && !advance, pend_valid_reg,
                    "scan stalled without held expiry")
    `OTP_ASSERT_NEXT(a_create_run, create_we, running_reg[$past(scan_idx_reg)],
                     "created slot not running")

endmodule
